/* sv/bbcache_pkg.sv */
// ============================================================================
// bbcache_pkg
// Shared types and codes for the block buffer cache directory.
// ============================================================================
package bbcache_pkg;

    localparam int REQ_W    = 2;
    localparam int DEV_W    = 8;
    localparam int BLK_W    = 32;
    localparam int IDX_W    = 5;
    localparam int TICK_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'hff;

    // request codes
    localparam logic [REQ_W-1:0] REQ_GET     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PIN     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNPIN   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STS_ALLOC  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NOFREE = 2'd2;

    // one directory entry as stored in memory
    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic [CNT_W-1:0]  cnt;
        logic [TICK_W-1:0] last_use;
        logic              filled;
    } entry_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_MODIFY,
        ST_DONE
    } state_t;

endpackage

/* sv/block_buffer_cache_lru_core.sv */
// ============================================================================
// block_buffer_cache_lru_core
// LRU block buffer cache directory: get, release, pin and unpin on a
// memory of ENTRIES directory words.
// ============================================================================
// Get: the scan reads one memory word per cycle, then the update state writes
//   back and the done state registers the result; no request is accepted meanwhile.
// Release / pin / unpin: read, then modify and write back, then output;
//   out-of-range entry index: straight to output, no memory access.
// Reset: async, active low; then a clearing pass writes zero to every entry,
//   during which no beat is accepted.
module block_buffer_cache_lru_core #(
    parameter int ENTRIES = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [bbcache_pkg::REQ_W-1:0]      req_type,
    input  logic [bbcache_pkg::DEV_W-1:0]      device,
    input  logic [bbcache_pkg::BLK_W-1:0]      block_number,
    input  logic [bbcache_pkg::IDX_W-1:0]      entry_index,
    input  logic [bbcache_pkg::TICK_W-1:0]     now_tick,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [bbcache_pkg::STATUS_W-1:0]   status,
    output logic [bbcache_pkg::IDX_W-1:0]      entry,
    output logic                               need_read
);
    import bbcache_pkg::*;

    // memory address width and last address
    localparam int            AW   = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    // ------------------------------------------------------------------
    // Directory memory: one write port, one registered read port
    // ------------------------------------------------------------------
    entry_word_t mem [ENTRIES];
    entry_word_t rd_data_reg;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    entry_word_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Control registers (reset)
    // ------------------------------------------------------------------
    state_t        state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          hit_found_reg, hit_found_next;
    logic          free_found_reg, free_found_next;
    logic          out_valid_reg, out_valid_next;

    // Payload registers (no reset)
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [DEV_W-1:0]    dev_reg, dev_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [AW-1:0]       hit_idx_reg, hit_idx_next;
    entry_word_t         hit_word_reg, hit_word_next;
    logic [AW-1:0]       free_idx_reg, free_idx_next;
    logic [TICK_W-1:0]   best_reg, best_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_entry_reg, res_entry_next;
    logic                res_need_reg, res_need_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]    entry_reg, entry_next;
    logic                need_reg, need_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        dev_reg        <= dev_next;
        blk_reg        <= blk_next;
        idx_reg        <= idx_next;
        tick_reg       <= tick_next;
        hit_idx_reg    <= hit_idx_next;
        hit_word_reg   <= hit_word_next;
        free_idx_reg   <= free_idx_next;
        best_reg       <= best_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        res_need_reg   <= res_need_next;
        status_reg     <= status_next;
        entry_reg      <= entry_next;
        need_reg       <= need_next;
    end

    // ------------------------------------------------------------------
    // Index conversions between the 5-bit port field and memory address
    // ------------------------------------------------------------------
    logic [31:0]   in_idx_ext;
    logic [31:0]   reg_idx_ext;
    logic [31:0]   hit_idx_ext;
    logic [31:0]   free_idx_ext;
    logic          in_idx_ok;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] reg_addr;

    assign in_idx_ext   = {{(32-IDX_W){1'b0}}, entry_index};
    assign reg_idx_ext  = {{(32-IDX_W){1'b0}}, idx_reg};
    assign hit_idx_ext  = {{(32-AW){1'b0}}, hit_idx_reg};
    assign free_idx_ext = {{(32-AW){1'b0}}, free_idx_reg};
    assign in_idx_ok    = (in_idx_ext < 32'(ENTRIES));
    assign in_addr      = in_idx_ext[AW-1:0];
    assign reg_addr     = reg_idx_ext[AW-1:0];

    // scan compares on the word just read
    logic tag_match;
    logic free_better;

    assign tag_match   = (rd_data_reg.dev == dev_reg) && (rd_data_reg.blk == blk_reg);
    assign free_better = (rd_data_reg.cnt == '0)
                         && (!free_found_reg || (rd_data_reg.last_use < best_reg));

    // ------------------------------------------------------------------
    // Next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        entry_word_t w;

        state_next      = state_reg;
        cnt_next        = cnt_reg;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        req_next        = req_reg;
        dev_next        = dev_reg;
        blk_next        = blk_reg;
        idx_next        = idx_reg;
        tick_next       = tick_reg;
        hit_idx_next    = hit_idx_reg;
        hit_word_next   = hit_word_reg;
        free_idx_next   = free_idx_reg;
        best_next       = best_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_need_next   = res_need_reg;
        status_next     = status_reg;
        entry_next      = entry_reg;
        need_next       = need_reg;

        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        w       = rd_data_reg;

        // output beat taken
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = req_type;
                    dev_next  = device;
                    blk_next  = block_number;
                    idx_next  = entry_index;
                    tick_next = now_tick;
                    if (req_type == REQ_GET)
                    begin
                        rd_en           = 1'b1;
                        rd_addr         = '0;
                        cnt_next        = '0;
                        hit_found_next  = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                    else if (in_idx_ok)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = in_addr;
                        state_next = ST_MODIFY;
                    end
                    else
                    begin
                        res_status_next = STS_DONE;
                        res_entry_next  = entry_index;
                        res_need_next   = 1'b0;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_SCAN:
            begin
                // first match wins; strict compare keeps lowest index on ties
                if (tag_match && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = cnt_reg;
                    hit_word_next  = rd_data_reg;
                end
                if (free_better)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cnt_reg;
                    best_next       = rd_data_reg.last_use;
                end
                if (cnt_reg == LAST)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = cnt_reg + 1'b1;
                end
            end

            ST_UPDATE:
            begin
                if (hit_found_reg)
                begin
                    w = hit_word_reg;
                    if (w.cnt != COUNT_MAX)
                    begin
                        w.cnt = w.cnt + 1'b1;
                    end
                    w.filled        = 1'b1;
                    wr_en           = 1'b1;
                    wr_addr         = hit_idx_reg;
                    wr_data         = w;
                    res_status_next = STS_DONE;
                    res_entry_next  = hit_idx_ext[IDX_W-1:0];
                    res_need_next   = !hit_word_reg.filled;
                end
                else if (free_found_reg)
                begin
                    w.dev           = dev_reg;
                    w.blk           = blk_reg;
                    w.cnt           = CNT_W'(1);
                    w.last_use      = best_reg;
                    w.filled        = 1'b1;
                    wr_en           = 1'b1;
                    wr_addr         = free_idx_reg;
                    wr_data         = w;
                    res_status_next = STS_ALLOC;
                    res_entry_next  = free_idx_ext[IDX_W-1:0];
                    res_need_next   = 1'b1;
                end
                else
                begin
                    res_status_next = STS_NOFREE;
                    res_entry_next  = '0;
                    res_need_next   = 1'b0;
                end
                state_next = ST_DONE;
            end

            ST_MODIFY:
            begin
                case (req_reg)
                    REQ_RELEASE:
                    begin
                        if (w.cnt != '0)
                        begin
                            // stamp only on the step down to zero
                            if (w.cnt == CNT_W'(1))
                            begin
                                w.last_use = tick_reg;
                            end
                            w.cnt = w.cnt - 1'b1;
                        end
                    end
                    REQ_PIN:
                    begin
                        if (w.cnt != COUNT_MAX)
                        begin
                            w.cnt = w.cnt + 1'b1;
                        end
                    end
                    REQ_UNPIN:
                    begin
                        if (w.cnt != '0)
                        begin
                            w.cnt = w.cnt - 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                wr_en           = 1'b1;
                wr_addr         = reg_addr;
                wr_data         = w;
                res_status_next = STS_DONE;
                res_entry_next  = idx_reg;
                res_need_next   = 1'b0;
                state_next      = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    entry_next     = res_entry_reg;
                    need_next      = res_need_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign entry     = entry_reg;
    assign need_read = need_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the LRU block buffer cache directory. A generator
// fills a short queue of requests, a clocked driver presents them with random
// gaps, and a clocked monitor compares each result beat with the oldest reply
// predicted by a shadow copy of the directory.
// ============================================================================
module testbench;

    import bbcache_pkg::*;

    localparam int ENTRIES  = 32;
    localparam int DRAIN_CY = ENTRIES + 8;   // quiet cycles after the last reply
    localparam int N_RANDOM = 1600;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic [IDX_W-1:0]  idx;
        logic [TICK_W-1:0] tick;
    } cache_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    entry;
        logic                need_read;
    } cache_reply_t;

    typedef enum int {
        MODE_MIXED,
        MODE_FILL,
        MODE_DRAIN
    } gen_mode_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type     = REQ_GET;
    logic [DEV_W-1:0]    device       = '0;
    logic [BLK_W-1:0]    block_number = '0;
    logic [IDX_W-1:0]    entry_index  = '0;
    logic [TICK_W-1:0]   now_tick     = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    entry;
    logic                need_read;

    always #5 clk = ~clk;

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    block_buffer_cache_lru_core #(
        .ENTRIES (ENTRIES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .device       (device),
        .block_number (block_number),
        .entry_index  (entry_index),
        .now_tick     (now_tick),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .entry        (entry),
        .need_read    (need_read)
    );

    // ------------------------------------------------------------------------
    // Shadow directory. Updated in the driver at the edge where a request
    // beat is accepted, so it always reflects every accepted request.
    // ------------------------------------------------------------------------
    logic [DEV_W-1:0]  dir_dev    [ENTRIES];
    logic [BLK_W-1:0]  dir_blk    [ENTRIES];
    logic [CNT_W-1:0]  dir_cnt    [ENTRIES];
    logic [TICK_W-1:0] dir_tick   [ENTRIES];
    logic              dir_filled [ENTRIES];

    cache_req_t   pending_reqs[$];   // requests waiting for the driver
    cache_reply_t due_replies[$];    // predicted replies, oldest first
    int           fail_count = 0;

    // Apply one request to the shadow directory and return its reply.
    task automatic serve_request(input cache_req_t rq, output cache_reply_t rp);
        int  k;
        int  pick;
        bit  hit;
        bit  found;
        logic [TICK_W-1:0] best;
        begin
            rp   = '{status: STS_DONE, entry: rq.idx, need_read: 1'b0};
            hit  = 1'b0;
            pick = 0;
            if (rq.kind == REQ_GET)
            begin
                // lowest matching index wins when several tags match
                for (k = 0; k < ENTRIES; k++)
                    if (!hit && dir_dev[k] == rq.dev && dir_blk[k] == rq.blk)
                    begin
                        hit  = 1'b1;
                        pick = k;
                    end
                if (hit)
                begin
                    rp.entry     = IDX_W'(pick);
                    rp.need_read = !dir_filled[pick];
                    if (dir_cnt[pick] != COUNT_MAX)
                        dir_cnt[pick] = dir_cnt[pick] + 1'b1;
                    dir_filled[pick] = 1'b1;
                end
                else
                begin
                    // oldest free entry; strict compare keeps the lowest index on ties
                    found = 1'b0;
                    best  = '1;
                    for (k = 0; k < ENTRIES; k++)
                        if (dir_cnt[k] == '0 && (!found || dir_tick[k] < best))
                        begin
                            found = 1'b1;
                            best  = dir_tick[k];
                            pick  = k;
                        end
                    if (!found)
                        rp = '{status: STS_NOFREE, entry: '0, need_read: 1'b0};
                    else
                    begin
                        dir_dev[pick]    = rq.dev;
                        dir_blk[pick]    = rq.blk;
                        dir_cnt[pick]    = 8'd1;
                        dir_filled[pick] = 1'b1;
                        rp = '{status: STS_ALLOC, entry: IDX_W'(pick), need_read: 1'b1};
                    end
                end
            end
            else if (int'(rq.idx) < ENTRIES)
            begin
                case (rq.kind)
                    REQ_RELEASE:
                        if (dir_cnt[rq.idx] != '0)
                        begin
                            dir_cnt[rq.idx] = dir_cnt[rq.idx] - 1'b1;
                            if (dir_cnt[rq.idx] == '0)
                                dir_tick[rq.idx] = rq.tick;
                        end
                    REQ_PIN:
                        if (dir_cnt[rq.idx] != COUNT_MAX)
                            dir_cnt[rq.idx] = dir_cnt[rq.idx] + 1'b1;
                    default:
                        if (dir_cnt[rq.idx] != '0)
                            dir_cnt[rq.idx] = dir_cnt[rq.idx] - 1'b1;
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: one beat per request, a random idle gap before each,
    // with occasional back-to-back bursts. A stalled beat is held untouched.
    // ------------------------------------------------------------------------
    cache_req_t drv_req;
    int         drv_gap   = 0;
    bit         drv_burst = 1'b0;

    always @(posedge clk)
    begin
        cache_reply_t rp;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            for (int k = 0; k < ENTRIES; k++)
            begin
                dir_dev[k]    = '0;
                dir_blk[k]    = '0;
                dir_cnt[k]    = '0;
                dir_tick[k]   = '0;
                dir_filled[k] = 1'b0;
            end
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                serve_request(drv_req, rp);
                due_replies.push_back(rp);
                if ($urandom_range(0, 63) == 0)
                    drv_burst = !drv_burst;
                drv_gap = drv_burst ? 0 : $urandom_range(0, 3);
            end
            // a stalled beat keeps valid and payload as they are
            if (!(in_valid && in_stall))
            begin
                if (drv_gap > 0)
                begin
                    drv_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    drv_req       = pending_reqs.pop_front();
                    req_type     <= drv_req.kind;
                    device       <= drv_req.dev;
                    block_number <= drv_req.blk;
                    entry_index  <= drv_req.idx;
                    now_tick     <= drv_req.tick;
                    in_valid     <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks every accepted result beat against the oldest predicted
    // reply, and stalls each result for a random wait (bursts with no stall too).
    // ------------------------------------------------------------------------
    int sink_wait  = 0;
    bit sink_burst = 1'b0;

    always @(posedge clk)
    begin
        cache_reply_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_replies.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected beat: status %0d entry %0d need_read %0b",
                                 status, entry, need_read);
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (status !== want.status || entry !== want.entry ||
                        need_read !== want.need_read)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch (exp/got): status %0d/%0d entry %0d/%0d",
                                     want.status, status, want.entry, entry,
                                     " need_read %0b/%0b", want.need_read, need_read);
                    end
                end
                if ($urandom_range(0, 63) == 0)
                    sink_burst = !sink_burst;
                sink_wait = sink_burst ? 0 : $urandom_range(0, 3);
            end
            // count only edges where a valid beat was actually held back
            if (sink_wait > 0)
            begin
                out_stall <= 1'b1;
                if (out_valid && out_stall)
                    sink_wait--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_req(input logic [REQ_W-1:0] kind, input logic [DEV_W-1:0] dev,
                            input logic [BLK_W-1:0] blk, input logic [IDX_W-1:0] idx,
                            input logic [TICK_W-1:0] tick);
        cache_req_t rq;
        begin
            rq = '{kind: kind, dev: dev, blk: blk, idx: idx, tick: tick};
            // keep the queue short so choices track the shadow directory
            while (pending_reqs.size() >= 2)
                @(posedge clk);
            pending_reqs.push_back(rq);
        end
    endtask

    // Random entry with a nonzero count, or any entry if none is held.
    function automatic logic [IDX_W-1:0] pick_held();
        int n;
        int want;
        logic [IDX_W-1:0] sel;
        begin
            n   = 0;
            sel = IDX_W'($urandom_range(0, ENTRIES - 1));
            for (int k = 0; k < ENTRIES; k++)
                if (dir_cnt[k] != '0)
                    n++;
            if (n > 0)
            begin
                want = $urandom_range(0, n - 1);
                for (int k = 0; k < ENTRIES; k++)
                    if (dir_cnt[k] != '0)
                    begin
                        if (want == 0)
                            sel = IDX_W'(k);
                        want--;
                    end
            end
            return sel;
        end
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid || due_replies.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: directed corners, then random traffic in segments.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [BLK_W-1:0]  blk_pool [48];
        logic [TICK_W-1:0] tick_now;
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        gen_mode_t         mode;
        int                n_random;
        int                seg_left;
        int                roll;
        bit                held_off;
        bit                stormed;
        logic [IDX_W-1:0]  storm_idx;

        blk_pool[0] = '0;
        blk_pool[1] = '1;
        for (int k = 2; k < 48; k++)
            blk_pool[k] = $urandom;
        tick_now = $urandom_range(1, 1000);
        n_random = 0;
        seg_left = 0;
        held_off = 1'b0;
        stormed  = 1'b0;
        mode     = MODE_MIXED;

        while (!rst_n)
            @(posedge clk);

        // all tags reset to zero: device 0 block 0 hits entry 0, unfilled
        push_req(REQ_GET, 8'h00, 32'h0000_0000, '0, '0);
        push_req(REQ_GET, 8'h00, 32'h0000_0000, '0, '0);
        // misses with equal stamps pick the lowest free index
        push_req(REQ_GET, 8'hff, 32'hffff_ffff, '1, '1);
        push_req(REQ_GET, 8'h5a, 32'ha5a5_a5a5, 5'd3, 32'h1234_5678);
        // release down to zero stamps the tick; a further release must not
        push_req(REQ_RELEASE, '0, '0, 5'd0, 32'hffff_ffff);
        push_req(REQ_RELEASE, '0, '0, 5'd0, 32'hffff_ffff);
        push_req(REQ_RELEASE, '0, '0, 5'd0, 32'd123);
        push_req(REQ_UNPIN, '0, '0, 5'd5, '0);
        push_req(REQ_PIN, '0, '0, 5'd31, '0);
        push_req(REQ_UNPIN, '0, '0, 5'd31, '0);
        push_req(REQ_RELEASE, '0, '0, 5'd1, 32'h0000_0000);
        push_req(REQ_GET, 8'h01, 32'h0000_0001, '0, '0);
        push_req(REQ_PIN, 8'hff, 32'hffff_ffff, 5'd2, '1);
        push_req(REQ_RELEASE, '0, '0, 5'd2, 32'h8000_0000);
        push_req(REQ_RELEASE, '0, '0, 5'd2, 32'h0000_0001);
        // entry 0 was filled but released: hit again, no read
        push_req(REQ_GET, 8'h00, 32'h0000_0000, '0, '0);
        push_req(REQ_GET, 8'h80, 32'h8000_0000, 5'd16, 32'h7fff_ffff);

        while (n_random < N_RANDOM)
        begin
            if (seg_left == 0)
            begin
                roll = $urandom_range(0, 99);
                mode = (roll < 50) ? MODE_MIXED : (roll < 75) ? MODE_FILL : MODE_DRAIN;
                seg_left = 48;
            end

            // once: let everything drain with the sender paused
            if (!held_off && n_random >= N_RANDOM / 2)
            begin
                held_off = 1'b1;
                wait_idle();
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end

            // once: drive one entry's count into saturation
            if (!stormed && n_random >= 300)
            begin
                stormed   = 1'b1;
                storm_idx = IDX_W'($urandom_range(0, ENTRIES - 1));
                for (int k = 0; k < 258; k++)
                    push_req(REQ_PIN, DEV_W'($urandom), $urandom, storm_idx, $urandom);
                n_random += 258;
            end

            // ticks mostly creep forward; repeats give equal stamps
            roll = $urandom_range(0, 19);
            if (roll == 0)
                tick_now = $urandom;
            else if (roll == 1)
                tick_now = '1;
            else
                tick_now = tick_now + $urandom_range(0, 3);

            dev = ($urandom_range(0, 7) == 0) ? DEV_W'($urandom)
                                              : DEV_W'($urandom_range(0, 3));
            blk = ($urandom_range(0, 7) == 0) ? $urandom : blk_pool[$urandom_range(0, 47)];
            roll = $urandom_range(0, 99);

            case (mode)
                MODE_FILL:
                    // fresh blocks mostly miss and exhaust the free entries
                    if (roll < 80)
                        push_req(REQ_GET, dev, $urandom, IDX_W'($urandom), tick_now);
                    else
                        push_req(REQ_RELEASE, dev, blk, pick_held(), tick_now);
                MODE_DRAIN:
                    if (roll < 70)
                        push_req(REQ_RELEASE, dev, blk, pick_held(), tick_now);
                    else if (roll < 85)
                        push_req(REQ_UNPIN, dev, blk, pick_held(), tick_now);
                    else
                        push_req(REQ_GET, dev, blk, IDX_W'($urandom), tick_now);
                default:
                    if (roll < 40)
                        push_req(REQ_GET, dev, blk, IDX_W'($urandom), tick_now);
                    else if (roll < 65)
                        push_req(REQ_RELEASE, dev, blk, pick_held(), tick_now);
                    else if (roll < 75)
                        push_req(REQ_PIN, dev, blk, pick_held(), tick_now);
                    else if (roll < 85)
                        push_req(REQ_UNPIN, dev, blk, pick_held(), tick_now);
                    else
                        // noise: every field at random
                        push_req(REQ_W'($urandom), DEV_W'($urandom), $urandom,
                                 IDX_W'($urandom), $urandom);
            endcase
            n_random++;
            seg_left--;
        end

        wait_idle();
        repeat (DRAIN_CY) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* block_buffer_cache_lru_core.f */
sv/bbcache_pkg.sv
sv/block_buffer_cache_lru_core.sv
tb/testbench.sv
